/* hw/rtl/rqs_pkg.sv */
// ----------------------------------------------------------------------------
// Ready-queue scheduler package
// Policy codes, command codes, register indexes and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rqs_pkg;

  // Scheduling policies.
  localparam logic [1:0] POL_SJF  = 2'd0;
  localparam logic [1:0] POL_PRIO = 2'd1;
  localparam logic [1:0] POL_FCFS = 2'd2;
  localparam logic [1:0] POL_RR   = 2'd3;

  // Input item commands.
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT = 1'b1;

  // Payload widths fixed by the item format.
  localparam int unsigned ID_W    = 8;
  localparam int unsigned BURST_W = 8;
  localparam int unsigned PRIO_W  = 4;
  localparam int unsigned STAT_W  = 16;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;    // latch the accepted input item, clear the result
    logic append;     // store the arriving process at the table tail
    logic idle_tick;  // report a tick on an empty table
    logic run;        // run the selected row for one unit
    logic retire;     // remove a finished row or advance the pointer
    logic time_inc;   // advance the saturating time counter
    logic sort_pass;  // one odd-even transposition pass
    logic sort_odd;   // parity of that pass
    logic load_out;   // move the result into the output register
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_tick;
    logic full;
    logic empty;
    logic sort_arrive;
    logic sort_pol;
    logic done;
  } ctl_sts_t;

endpackage

/* hw/rtl/rqs_in_if.sv */
// ----------------------------------------------------------------------------
// Scheduler input channel
// Valid/ready channel carrying one arrive or tick command.
// ----------------------------------------------------------------------------
interface rqs_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] proc_id;
  logic [7:0] burst;
  logic [3:0] prio_level;

  modport source(output valid, command, proc_id, burst, prio_level, input ready);
  modport sink(input valid, command, proc_id, burst, prio_level, output ready);
endinterface

/* hw/rtl/rqs_out_if.sv */
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying one result per command.
// ----------------------------------------------------------------------------
interface rqs_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        idle;
  logic [7:0]  ran_id;
  logic        finished;
  logic [15:0] turnaround;
  logic [15:0] waiting;

  modport source(output valid, accepted, idle, ran_id, finished, turnaround, waiting,
                 input ready);
  modport sink(input valid, accepted, idle, ran_id, finished, turnaround, waiting,
               output ready);
endinterface

/* hw/rtl/rqs_cfg_if.sv */
// ----------------------------------------------------------------------------
// Scheduler configuration channel
// Valid/ready register write channel with index and data.
// ----------------------------------------------------------------------------
interface rqs_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/rqs_ctrl.sv */
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one command at a time through decode, run, retire, sort and
// result hand-off, and owns the output valid flag.
// ----------------------------------------------------------------------------
module rqs_ctrl #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rqs_pkg::ctl_sts_t sts,
  output rqs_pkg::ctl_cmd_t cmd
);
  import rqs_pkg::*;

  localparam int unsigned PASS_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_FIN    = 3'd3;
  localparam logic [2:0] S_SORT   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        pass_nxt = '0;
        if (sts.is_tick) begin
          if (sts.empty) begin
            cmd.idle_tick = 1'b1;
            cmd.time_inc  = 1'b1;
            state_nxt     = S_RESP;
          end else begin
            state_nxt = S_RUN;
          end
        end else if (sts.full) begin
          state_nxt = S_RESP;
        end else begin
          cmd.append = 1'b1;
          state_nxt  = sts.sort_arrive ? S_SORT : S_RESP;
        end
      end
      S_RUN: begin
        cmd.run   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.retire   = 1'b1;
        cmd.time_inc = 1'b1;
        pass_nxt     = '0;
        state_nxt    = (sts.done && sts.sort_pol) ? S_SORT : S_RESP;
      end
      S_SORT: begin
        cmd.sort_pass = 1'b1;
        cmd.sort_odd  = pass_r[0];
        pass_nxt      = pass_r + 1'b1;
        if (pass_r == PASS_W'(MAX_PROCS - 1)) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // One command at a time: an accepted transfer closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a command is in flight");

  // A result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwrote a pending transfer");

endmodule

/* hw/rtl/rqs_datapath.sv */
// ----------------------------------------------------------------------------
// Scheduler datapath
// Ready table in registers, time counter, round-robin pointer, policy
// registers, odd-even transposition sorter and result registers.
// ----------------------------------------------------------------------------
module rqs_datapath #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rqs_pkg::ctl_cmd_t                cmd,
  output rqs_pkg::ctl_sts_t                sts,
  input  logic                             cfg_we,
  input  logic [rqs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [1:0]                       cfg_data,
  input  logic                             in_command,
  input  logic [rqs_pkg::ID_W-1:0]         in_proc_id,
  input  logic [rqs_pkg::BURST_W-1:0]      in_burst,
  input  logic [rqs_pkg::PRIO_W-1:0]       in_prio_level,
  output logic                             out_accepted,
  output logic                             out_idle,
  output logic [rqs_pkg::ID_W-1:0]         out_ran_id,
  output logic                             out_finished,
  output logic [rqs_pkg::STAT_W-1:0]       out_turnaround,
  output logic [rqs_pkg::STAT_W-1:0]       out_waiting
);
  import rqs_pkg::*;

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned TT_W  = TIME_BITS + 1;

  // Ready table.
  logic [ID_W-1:0]      id_r    [MAX_PROCS];
  logic [BURST_W-1:0]   rem_r   [MAX_PROCS];
  logic [BURST_W-1:0]   bst_r   [MAX_PROCS];
  logic [PRIO_W-1:0]    pri_r   [MAX_PROCS];
  logic [TIME_BITS-1:0] arr_r   [MAX_PROCS];
  logic [ID_W-1:0]      id_nxt  [MAX_PROCS];
  logic [BURST_W-1:0]   rem_nxt [MAX_PROCS];
  logic [BURST_W-1:0]   bst_nxt [MAX_PROCS];
  logic [PRIO_W-1:0]    pri_nxt [MAX_PROCS];
  logic [TIME_BITS-1:0] arr_nxt [MAX_PROCS];
  logic [BURST_W-1:0]   key     [MAX_PROCS];
  logic [MAX_PROCS-1:0] swp;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [IDX_W-1:0]     rr_r, rr_nxt;
  logic [1:0]           pol_r;
  logic                 pre_r;

  // Latched command and working result.
  logic                 cmd_r;
  logic [ID_W-1:0]      pid_r;
  logic [BURST_W-1:0]   pb_r;
  logic [PRIO_W-1:0]    pp_r;
  logic [IDX_W-1:0]     sel_r;
  logic                 done_r;
  logic [TT_W-1:0]      turn_r;
  logic [BURST_W-1:0]   sb_r;
  logic                 res_acc_r, res_idle_r, res_fin_r;
  logic [ID_W-1:0]      res_id_r;
  logic [STAT_W-1:0]    res_turn_r, res_wait_r;

  logic [IDX_W-1:0]     sel_run;
  logic [IDX_W-1:0]     tail;
  logic [TT_W-1:0]      wait_full;
  logic                 sort_pol;

  assign sort_pol = (pol_r == POL_SJF) || (pol_r == POL_PRIO);
  assign tail     = cnt_r[IDX_W-1:0];

  // Row that runs on this tick; the round-robin pointer wraps first.
  always_comb begin
    if (pol_r == POL_RR && CNT_W'(rr_r) < cnt_r) begin
      sel_run = rr_r;
    end else begin
      sel_run = '0;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.is_tick     = (cmd_r == CMD_TICK);
    sts.full        = (cnt_r >= CNT_W'(MAX_PROCS));
    sts.empty       = (cnt_r == '0);
    sts.sort_arrive = sort_pol && (pre_r || now_r == '0);
    sts.sort_pol    = sort_pol;
    sts.done        = done_r;
  end

  // Sort keys and swap decisions for the current pass.
  always_comb begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      key[i] = (pol_r == POL_SJF) ? rem_r[i] : BURST_W'(pri_r[i]);
    end
    swp = '0;
    for (int j = 0; j + 1 < MAX_PROCS; j++) begin
      if ((j % 2) == int'(cmd.sort_odd) && CNT_W'(j + 1) < cnt_r &&
          key[j] > key[j + 1]) begin
        swp[j] = 1'b1;
      end
    end
  end

  // Table next state.
  always_comb begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      id_nxt[i]  = id_r[i];
      rem_nxt[i] = rem_r[i];
      bst_nxt[i] = bst_r[i];
      pri_nxt[i] = pri_r[i];
      arr_nxt[i] = arr_r[i];
      if (cmd.append && IDX_W'(i) == tail) begin
        id_nxt[i]  = pid_r;
        rem_nxt[i] = (pb_r == '0) ? BURST_W'(1) : pb_r;
        bst_nxt[i] = (pb_r == '0) ? BURST_W'(1) : pb_r;
        pri_nxt[i] = pp_r;
        arr_nxt[i] = now_r;
      end
      if (cmd.run && IDX_W'(i) == sel_run && rem_r[i] != '0) begin
        rem_nxt[i] = rem_r[i] - 1'b1;
      end
      if (cmd.retire && done_r && IDX_W'(i) >= sel_r && i + 1 < MAX_PROCS) begin
        id_nxt[i]  = id_r[(i + 1) % MAX_PROCS];
        rem_nxt[i] = rem_r[(i + 1) % MAX_PROCS];
        bst_nxt[i] = bst_r[(i + 1) % MAX_PROCS];
        pri_nxt[i] = pri_r[(i + 1) % MAX_PROCS];
        arr_nxt[i] = arr_r[(i + 1) % MAX_PROCS];
      end
      if (cmd.sort_pass) begin
        if (i + 1 < MAX_PROCS && swp[i]) begin
          id_nxt[i]  = id_r[(i + 1) % MAX_PROCS];
          rem_nxt[i] = rem_r[(i + 1) % MAX_PROCS];
          bst_nxt[i] = bst_r[(i + 1) % MAX_PROCS];
          pri_nxt[i] = pri_r[(i + 1) % MAX_PROCS];
          arr_nxt[i] = arr_r[(i + 1) % MAX_PROCS];
        end else if (i > 0 && swp[(i + MAX_PROCS - 1) % MAX_PROCS]) begin
          id_nxt[i]  = id_r[(i + MAX_PROCS - 1) % MAX_PROCS];
          rem_nxt[i] = rem_r[(i + MAX_PROCS - 1) % MAX_PROCS];
          bst_nxt[i] = bst_r[(i + MAX_PROCS - 1) % MAX_PROCS];
          pri_nxt[i] = pri_r[(i + MAX_PROCS - 1) % MAX_PROCS];
          arr_nxt[i] = arr_r[(i + MAX_PROCS - 1) % MAX_PROCS];
        end
      end
    end
  end

  // Count, pointer and time counter next state.
  always_comb begin
    cnt_nxt = cnt_r;
    rr_nxt  = rr_r;
    now_nxt = now_r;
    if (cmd.append) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.run && pol_r == POL_RR) begin
      rr_nxt = sel_run;
    end
    if (cmd.retire) begin
      if (done_r) begin
        cnt_nxt = cnt_r - 1'b1;
        if (pol_r == POL_RR && CNT_W'(rr_r) >= cnt_r - 1'b1) begin
          rr_nxt = '0;
        end
      end else if (pol_r == POL_RR) begin
        rr_nxt = (CNT_W'(rr_r) + 1'b1 >= cnt_r) ? '0 : rr_r + 1'b1;
      end
    end
    if (cmd.time_inc && now_r != '1) begin
      now_nxt = now_r + 1'b1;
    end
  end

  // Waiting time from the registered turnaround.
  assign wait_full = (turn_r > TT_W'(sb_r)) ? turn_r - TT_W'(sb_r) : '0;

  // Table storage; rows hold payload only.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      id_r[i]  <= id_nxt[i];
      rem_r[i] <= rem_nxt[i];
      bst_r[i] <= bst_nxt[i];
      pri_r[i] <= pri_nxt[i];
      arr_r[i] <= arr_nxt[i];
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      now_r <= '0;
      rr_r  <= '0;
      pol_r <= POL_SJF;
      pre_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      now_r <= now_nxt;
      rr_r  <= rr_nxt;
      if (cfg_we && cfg_idx == CFG_POLICY) begin
        pol_r <= cfg_data;
      end
      if (cfg_we && cfg_idx == CFG_PREEMPT) begin
        pre_r <= cfg_data[0];
      end
    end
  end

  // Working registers for the command in flight.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r      <= in_command;
      pid_r      <= in_proc_id;
      pb_r       <= in_burst;
      pp_r       <= in_prio_level;
      res_acc_r  <= in_command == CMD_TICK;
      res_idle_r <= 1'b0;
      res_fin_r  <= 1'b0;
      res_id_r   <= '0;
      res_turn_r <= '0;
      res_wait_r <= '0;
      done_r     <= 1'b0;
    end
    if (cmd.append) begin
      res_acc_r <= 1'b1;
    end
    if (cmd.idle_tick) begin
      res_idle_r <= 1'b1;
    end
    if (cmd.run) begin
      sel_r     <= sel_run;
      res_id_r  <= id_r[sel_run];
      done_r    <= rem_r[sel_run] <= BURST_W'(1);
      res_fin_r <= rem_r[sel_run] <= BURST_W'(1);
      sb_r      <= bst_r[sel_run];
      turn_r    <= TT_W'(now_r) + 1'b1 - TT_W'(arr_r[sel_run]);
    end
    if (cmd.retire && done_r) begin
      res_turn_r <= ((turn_r >> STAT_W) != '0) ? '1 : STAT_W'(turn_r);
      res_wait_r <= ((wait_full >> STAT_W) != '0) ? '1 : STAT_W'(wait_full);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_accepted   <= res_acc_r;
      out_idle       <= res_idle_r;
      out_ran_id     <= res_id_r;
      out_finished   <= res_fin_r;
      out_turnaround <= res_turn_r;
      out_waiting    <= res_wait_r;
    end
  end

  // The table never holds more rows than it has.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PROCS))
    else $error("ready table count out of range");

  // Retiring a finished process drops exactly one row.
  a_retire_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.retire && done_r) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("finished process not removed");

  // A rejected arrival leaves the table unchanged.
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.full && !sts.is_tick) |-> !cmd.append)
    else $error("append into a full table");

endmodule

/* hw/rtl/ready_queue_cpu_scheduler_top.sv */
// ----------------------------------------------------------------------------
// Ready-queue CPU scheduler
// Top level: controller and datapath for a SJF, priority, FCFS and
// round-robin ready table with a saturating tick counter.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per transfer: arrive (proc_id, burst,
//   prio_level) or tick. out_ch returns exactly one result per command.
//   cfg_ch writes policy (index 0) and preemptive (index 1); it is always
//   ready. The user writes it only while no command is in flight; the
//   block does not enforce this. Commands are handled one at a time. A
//   rejected arrive, a plain arrive or an idle tick goes from decode to
//   the result; a tick that runs a process passes through decode, run,
//   retire and result. An arrive that re-sorts the table, or a finished
//   process under SJF or priority, adds MAX_PROCS odd-even transposition
//   passes over the table. in_ch.ready rises again in the cycle after the
//   result is loaded into the output register, so the next command
//   overlaps a waiting result. When the receiver stalls, a second result
//   waits in the datapath registers until the output register is taken.
//   Reset empties the table, clears the time counter and pointer, and
//   selects non-preemptive SJF.
// ----------------------------------------------------------------------------
module ready_queue_cpu_scheduler_top #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  rqs_in_if.sink    in_ch,
  rqs_out_if.source out_ch,
  rqs_cfg_if.sink   cfg_ch
);
  import rqs_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  // Sequencer.
  rqs_ctrl #(
    .MAX_PROCS(MAX_PROCS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, counters and result registers.
  rqs_datapath #(
    .MAX_PROCS(MAX_PROCS),
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_ch.valid),
    .cfg_idx       (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .in_command    (in_ch.command),
    .in_proc_id    (in_ch.proc_id),
    .in_burst      (in_ch.burst),
    .in_prio_level (in_ch.prio_level),
    .out_accepted  (out_ch.accepted),
    .out_idle      (out_ch.idle),
    .out_ran_id    (out_ch.ran_id),
    .out_finished  (out_ch.finished),
    .out_turnaround(out_ch.turnaround),
    .out_waiting   (out_ch.waiting)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready-queue scheduler testbench
// Sends arrive and tick commands under every policy and preemption setting,
// with random bursts, gaps and receiver stalls. A behavioral copy of the
// scheduler predicts each result. The monitor checks every result against
// that prediction in order. A closing phase runs a short round-robin
// sequence with the receiver always ready.
// ----------------------------------------------------------------------------
module tb_top;
  import rqs_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN, K_QUIET} stim_kind_t;

  typedef struct {
    stim_kind_t           kind;
    logic                 command;
    logic [ID_W-1:0]      proc_id;
    logic [BURST_W-1:0]   burst;
    logic [PRIO_W-1:0]    prio_level;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [1:0]           cfg_data;
  } stim_t;

  typedef struct packed {
    logic              accepted;
    logic              idle;
    logic [ID_W-1:0]   ran_id;
    logic              finished;
    logic [STAT_W-1:0] turnaround;
    logic [STAT_W-1:0] waiting;
  } sched_res_t;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [15:0]        arrival;
  } proc_row_t;

  logic clk;
  logic rst_n;

  rqs_in_if  in_ch();
  rqs_out_if out_ch();
  rqs_cfg_if cfg_ch();

  ready_queue_cpu_scheduler_top i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Stimulus and expected results.
  stim_t      stim_q[$];
  sched_res_t sched_res_q[$];
  stim_t      cur_item;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          quiet;

  // Predicted scheduler state.
  proc_row_t   ready_tbl[TABLE_DEPTH];
  int unsigned ready_count;
  logic [15:0] now_tick;
  int unsigned rr_ptr;
  logic [1:0]  cur_policy;
  logic        cur_preempt;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned row_key(int unsigned i);
    return (cur_policy == POL_SJF) ? ready_tbl[i].remaining : ready_tbl[i].prio;
  endfunction

  // Stable insertion sort by the key of the current policy.
  task automatic sort_ready_table();
    int unsigned i;
    int unsigned j;
    proc_row_t   tmp;
    if (cur_policy != POL_SJF && cur_policy != POL_PRIO) return;
    for (i = 1; i < ready_count; i++) begin
      j = i;
      while (j > 0 && row_key(j - 1) > row_key(j)) begin
        tmp              = ready_tbl[j - 1];
        ready_tbl[j - 1] = ready_tbl[j];
        ready_tbl[j]     = tmp;
        j--;
      end
    end
  endtask

  // Advance the predicted scheduler by one command and return its result.
  task automatic schedule_step(input stim_t it, output sched_res_t res);
    logic [BURST_W-1:0] b;
    int unsigned        row;
    int unsigned        i;
    logic [16:0]        turn;
    logic [16:0]        wait_t;
    res = '0;
    if (it.command == CMD_ARRIVE) begin
      if (ready_count >= TABLE_DEPTH) return;
      b = (it.burst == 0) ? 8'd1 : it.burst;
      ready_tbl[ready_count] = '{id: it.proc_id, remaining: b, burst: b,
                                 prio: it.prio_level, arrival: now_tick};
      ready_count++;
      if (cur_preempt || now_tick == 0) sort_ready_table();
      res.accepted = 1'b1;
      return;
    end
    res.accepted = 1'b1;
    if (ready_count == 0) begin
      res.idle = 1'b1;
    end else begin
      if (cur_policy == POL_RR) begin
        if (rr_ptr >= ready_count) rr_ptr = 0;
        row = rr_ptr;
      end else begin
        row = 0;
      end
      if (ready_tbl[row].remaining > 0) ready_tbl[row].remaining--;
      res.ran_id = ready_tbl[row].id;
      if (ready_tbl[row].remaining == 0) begin
        turn   = {1'b0, now_tick} + 17'd1 - {1'b0, ready_tbl[row].arrival};
        wait_t = (turn > ready_tbl[row].burst) ? turn - ready_tbl[row].burst : '0;
        res.finished   = 1'b1;
        res.turnaround = (turn > 17'hFFFF) ? 16'hFFFF : turn[15:0];
        res.waiting    = (wait_t > 17'hFFFF) ? 16'hFFFF : wait_t[15:0];
        for (i = row; i + 1 < ready_count; i++) ready_tbl[i] = ready_tbl[i + 1];
        ready_count--;
        if (cur_policy == POL_RR) begin
          if (rr_ptr >= ready_count) rr_ptr = 0;
        end else begin
          sort_ready_table();
        end
      end else if (cur_policy == POL_RR) begin
        rr_ptr++;
        if (rr_ptr >= ready_count) rr_ptr = 0;
      end
    end
    if (now_tick != 16'hFFFF) now_tick++;
  endtask

  // Stimulus builders.
  function automatic void push_cmd(logic cmd, logic [7:0] id, logic [7:0] b, logic [3:0] p);
    stim_t s;
    s = '{kind: K_ITEM, command: cmd, proc_id: id, burst: b, prio_level: p,
          cfg_index: '0, cfg_data: '0};
    stim_q = {stim_q, s};
  endfunction

  function automatic void push_ctrl(stim_kind_t k, logic [CFG_IDX_W-1:0] idx, logic [1:0] d);
    stim_t s;
    s = '{kind: k, command: CMD_TICK, proc_id: '0, burst: '0, prio_level: '0,
          cfg_index: idx, cfg_data: d};
    stim_q = {stim_q, s};
  endfunction

  // Wait for idle, then write both registers.
  function automatic void push_setting(logic [1:0] pol, logic pre);
    push_ctrl(K_DRAIN, '0, '0);
    push_ctrl(K_CFG, CFG_POLICY, pol);
    push_ctrl(K_CFG, CFG_PREEMPT, {1'b0, pre});
  endfunction

  function automatic void push_random(int unsigned arrive_pct);
    logic [7:0] b;
    if ($urandom_range(0, 99) < arrive_pct) begin
      b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 6));
      push_cmd(CMD_ARRIVE, 8'($urandom), b, 4'($urandom));
    end else begin
      push_cmd(CMD_TICK, 8'($urandom), 8'($urandom), 4'($urandom));
    end
  endfunction

  function automatic void build_stimulus();
    logic [1:0]  pol_list[8];
    int unsigned p;
    int unsigned n;
    pol_list = '{POL_SJF, POL_PRIO, POL_FCFS, POL_RR, POL_RR, POL_FCFS, POL_PRIO, POL_SJF};

    // Directed: sort at time zero, zero burst, field extremes, full table.
    push_setting(POL_SJF, 1'b0);
    push_cmd(CMD_ARRIVE, 8'd255, 8'd255, 4'd15);
    push_cmd(CMD_ARRIVE, 8'd0, 8'd0, 4'd0);
    push_cmd(CMD_TICK, 8'd0, 8'd0, 4'd0);
    for (n = 0; n < 16; n++) push_cmd(CMD_ARRIVE, 8'(n + 1), 8'(n % 3 + 1), 4'(15 - n));
    for (n = 0; n < 4; n++) push_cmd(CMD_TICK, 8'hFF, 8'hFF, 4'hF);

    // Random phases over every policy and preemption setting.
    for (p = 0; p < 8; p++) begin
      push_setting(pol_list[p], p[0]);
      for (n = 0; n < 66; n++) begin
        if (n == 33) push_ctrl(K_DRAIN, '0, '0);
        push_random((p == 2) ? 75 : 25 + 10 * (p % 4));
      end
    end

    // Finish with the receiver always ready and a short round-robin run.
    push_ctrl(K_QUIET, '0, 2'd1);
    push_setting(POL_RR, 1'b1);
    push_cmd(CMD_ARRIVE, 8'hA5, 8'd3, 4'd2);
    push_cmd(CMD_ARRIVE, 8'h5A, 8'd1, 4'd1);
    for (n = 0; n < 6; n++) push_cmd(CMD_TICK, '0, '0, '0);
  endfunction

  // Driver: input and configuration channels, bursts with random gaps.
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned settle;

  always @(posedge clk) begin
    logic in_next;
    logic cfg_next;
    stim_t s;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
      burst_left   = 0;
      gap_left     = 0;
      settle       = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sched_res_t r;
        schedule_step(cur_item, r);
        sched_res_q = {sched_res_q, r};
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_POLICY) cur_policy = cfg_ch.data;
        else cur_preempt = cfg_ch.data[0];
      end
      if (!((in_ch.valid && !in_ch.ready) || (cfg_ch.valid && !cfg_ch.ready))) begin
        in_next  = 1'b0;
        cfg_next = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          case (stim_q[0].kind)
            K_ITEM: begin
              cur_item = stim_q.pop_front();
              in_next  = 1'b1;
              in_ch.command    <= cur_item.command;
              in_ch.proc_id    <= cur_item.proc_id;
              in_ch.burst      <= cur_item.burst;
              in_ch.prio_level <= cur_item.prio_level;
              if (!quiet) begin
                if (burst_left > 0) begin
                  burst_left--;
                end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
              end
            end
            K_CFG: begin
              s        = stim_q.pop_front();
              cfg_next = 1'b1;
              cfg_ch.index <= s.cfg_index;
              cfg_ch.data  <= s.cfg_data;
            end
            K_DRAIN: begin
              // Hold off until every result is back, then let the block settle.
              if (sched_res_q.size() != 0) begin
                settle = 0;
              end else if (settle >= SETTLE_CYCLES) begin
                settle = 0;
                void'(stim_q.pop_front());
              end else begin
                settle++;
              end
            end
            default: begin
              s     = stim_q.pop_front();
              quiet = s.cfg_data[0];
            end
          endcase
        end
        in_ch.valid  <= in_next;
        cfg_ch.valid <= cfg_next;
      end
    end
  end

  // Monitor: receiver stall pattern and result checking.
  int unsigned stall_mode;
  int unsigned stall_cnt;

  always @(posedge clk) begin
    sched_res_t want;
    sched_res_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode   = 0;
      stall_cnt    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.accepted, out_ch.idle, out_ch.ran_id, out_ch.finished,
                out_ch.turnaround, out_ch.waiting};
        if (sched_res_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transfer: %p", got);
        end else begin
          want = sched_res_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      // The stall pattern is redrawn each time stall_cnt reaches its limit.
      stall_cnt++;
      if (stall_cnt >= 100) begin
        stall_cnt  = 0;
        stall_mode = $urandom_range(0, 3);
      end
      if (quiet) out_ch.ready <= 1'b1;
      else begin
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (stall_cnt % 3 == 0);
        endcase
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Reset, stimulus, and end of run.
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_TICK;
    in_ch.proc_id    = '0;
    in_ch.burst      = '0;
    in_ch.prio_level = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_POLICY;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    quiet            = 1'b0;
    ready_count      = 0;
    now_tick         = '0;
    rr_ptr           = 0;
    cur_policy       = POL_SJF;
    cur_preempt      = 1'b0;
    build_stimulus();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (stim_q.size() != 0 || in_ch.valid || sched_res_q.size() != 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && sched_res_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
